// File: design/rftb_pkg.sv
// rftb_pkg: shared types and constants for the row fir threshold binarizer
`timescale 1ns / 1ps

package rftb_pkg;

    // field and register widths
    localparam int PIX_W       = 8;
    localparam int IDX_W       = 32;
    localparam int COEF_W      = 12;
    localparam int COEF_LOW_W  = 60;
    localparam int COEF_HIGH_W = 48;
    localparam int THRESH_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 60;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGH = 2'd3;

    // configuration reset values (kernel is a unit centre tap)
    localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd128;
    localparam logic                   PAD_MODE_RST  = 1'b1;
    localparam logic [COEF_LOW_W-1:0]  COEF_LOW_RST  = 60'h100000000000000;
    localparam logic [COEF_HIGH_W-1:0] COEF_HIGH_RST = 48'h0;

    // input command codes
    localparam logic CMD_PIXELS = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // input beat
    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [PIX_W-1:0] first_pixel;
        logic [PIX_W-1:0] second_pixel;
    } pix_beat_t;

    // result beat
    typedef struct packed {
        logic             bit_first;
        logic             bit_second;
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic             last_of_run;
    } res_beat_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_MAC,
        S_BIT,
        S_LONE,
        S_NEWROW,
        S_DONE
    } ctrl_state_t;

    // source of the sample shifted into the window
    typedef enum logic [1:0] {
        SRC_FLUSH_PAD,
        SRC_LEFT_PAD,
        SRC_FIRST,
        SRC_SECOND
    } push_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      push;
        push_src_t src;
        logic      mac_step;
        logic      mac_first;
        logic      bit_commit;
        logic      emit_lone;
        logic      row_clear;
        logic      row_start;
        logic      release_held;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic cmd_flush;
        logic row_seen;
        logic row_match;
        logic will_fill;
        logic pending_valid;
        logic held_valid;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/rftb_ctrl.sv
// rftb_ctrl: sequencing state machine for window pushes, mac passes and result release
`timescale 1ns / 1ps

module rftb_ctrl
    import rftb_pkg::*;
#(
    parameter int TAPS = 9
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    output logic                       pix_ready,
    input  dp_status_t                 status,
    output ctrl_cmd_t                  cmd,
    output logic [$clog2(TAPS)-1:0]    tap_sel
);

    localparam int HALF  = TAPS / 2;
    localparam int TAP_W = $clog2(TAPS);
    localparam int PAD_W = (HALF > 1) ? $clog2(HALF) : 1;

    ctrl_state_t      state_reg, state_next;
    push_src_t        phase_reg, phase_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic [TAP_W-1:0] tap_reg, tap_next;

    // where to go once one push is complete
    ctrl_state_t      adv_state;
    push_src_t        adv_phase;
    logic [PAD_W-1:0] adv_pad;

    // a commit that makes a result needs room to move the held result out
    logic             emit_blocked;

    assign tap_sel = tap_reg;
    assign emit_blocked = status.pending_valid && status.held_valid && !status.out_free;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= SRC_FIRST;
            pad_reg   <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            tap_reg   <= tap_next;
        end
    end

    // step after a push, by phase
    always_comb
    begin
        adv_state = S_SHIFT;
        adv_phase = phase_reg;
        adv_pad   = pad_reg;
        case (phase_reg)
            SRC_FLUSH_PAD:
            begin
                if (pad_reg == PAD_W'(HALF - 1))
                    adv_state = S_LONE;
                else
                    adv_pad = pad_reg + 1'b1;
            end
            SRC_LEFT_PAD:
            begin
                if (pad_reg == PAD_W'(HALF - 1))
                    adv_phase = SRC_FIRST;
                else
                    adv_pad = pad_reg + 1'b1;
            end
            SRC_FIRST:
                adv_phase = SRC_SECOND;
            default:
                adv_state = S_DONE;
        endcase
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pad_next   = pad_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        cmd.src    = phase_reg;
        pix_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                pix_ready = 1'b1;
                if (pix_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                pad_next = '0;
                if (status.cmd_flush)
                begin
                    phase_next = SRC_FLUSH_PAD;
                    state_next = status.row_seen ? S_SHIFT : S_DONE;
                end
                else if (status.row_seen && status.row_match)
                begin
                    phase_next = SRC_FIRST;
                    state_next = S_SHIFT;
                end
                else if (status.row_seen)
                begin
                    phase_next = SRC_FLUSH_PAD;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_NEWROW;
                end
            end
            S_SHIFT:
            begin
                cmd.push = 1'b1;
                if (status.will_fill)
                begin
                    tap_next   = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = adv_state;
                    phase_next = adv_phase;
                    pad_next   = adv_pad;
                end
            end
            S_MAC:
            begin
                cmd.mac_step  = 1'b1;
                cmd.mac_first = (tap_reg == '0);
                if (tap_reg == TAP_W'(TAPS - 1))
                    state_next = S_BIT;
                else
                    tap_next = tap_reg + 1'b1;
            end
            S_BIT:
            begin
                if (!emit_blocked)
                begin
                    cmd.bit_commit = 1'b1;
                    state_next     = adv_state;
                    phase_next     = adv_phase;
                    pad_next       = adv_pad;
                end
            end
            S_LONE:
            begin
                if (!emit_blocked)
                begin
                    cmd.emit_lone = 1'b1;
                    if (status.cmd_flush)
                    begin
                        cmd.row_clear = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_NEWROW;
                    end
                end
            end
            S_NEWROW:
            begin
                cmd.row_start = 1'b1;
                phase_next    = SRC_LEFT_PAD;
                pad_next      = '0;
                state_next    = S_SHIFT;
            end
            S_DONE:
            begin
                if (!(status.held_valid && !status.out_free))
                begin
                    cmd.release_held = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // an accepted beat is always examined in the next cycle
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> (state_reg == S_DECIDE))
        else $error("accepted beat not followed by decision");

    // a mac pass ends after exactly TAPS products
    a_mac_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC && tap_reg == TAP_W'(TAPS - 1)) |=> (state_reg == S_BIT))
        else $error("mac pass did not end at the last tap");
`endif

endmodule

// File: design/rftb_datapath.sv
// rftb_datapath: config registers, sample window, mac unit, pairing and output registers
`timescale 1ns / 1ps

module rftb_datapath
    import rftb_pkg::*;
#(
    parameter int TAPS = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  pix_beat_t               pix_data,
    input  ctrl_cmd_t               cmd,
    input  logic [$clog2(TAPS)-1:0] tap_sel,
    output dp_status_t              status,
    output logic                    res_valid,
    input  logic                    res_ready,
    output res_beat_t               res_data
);

    localparam int HALF   = TAPS / 2;
    localparam int NT     = TAPS - HALF;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int COEF_ALL_W = COEF_LOW_W + COEF_HIGH_W;

    // configuration
    logic [THRESH_W-1:0]    threshold_reg, threshold_next;
    logic                   pad_mode_reg, pad_mode_next;
    logic [COEF_LOW_W-1:0]  coef_low_reg, coef_low_next;
    logic [COEF_HIGH_W-1:0] coef_high_reg, coef_high_next;

    // item and row state
    pix_beat_t          item_reg, item_next;
    logic [PIX_W-1:0]   win_reg [TAPS];
    logic [PIX_W-1:0]   win_next [TAPS];
    logic [IDX_W-1:0]   tag_reg [NT];
    logic [IDX_W-1:0]   tag_next [NT];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   cur_row_reg, cur_row_next;
    logic               row_seen_reg, row_seen_next;
    logic [PIX_W-1:0]   last_pix_reg, last_pix_next;
    logic [IDX_W-1:0]   last_col_reg, last_col_next;
    logic               pend_bit_reg, pend_bit_next;
    logic [IDX_W-1:0]   pend_col_reg, pend_col_next;
    logic               pend_valid_reg, pend_valid_next;

    // mac and result staging
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    held_valid_reg, held_valid_next;
    res_beat_t               held_reg, held_next;
    logic                    out_valid_reg, out_valid_next;
    res_beat_t               out_reg, out_next;

    logic [COEF_ALL_W-1:0]    coef_all;
    logic signed [COEF_W-1:0] coef_tap;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  thr_ext;
    logic                     new_bit;
    logic                     out_free;
    logic [PIX_W-1:0]         push_pix;
    logic [IDX_W-1:0]         push_tag;
    logic                     emit_en;
    res_beat_t                emit_beat;

    // product of one tap
    assign coef_all = {coef_high_reg, coef_low_reg};
    assign coef_tap = coef_all[tap_sel * COEF_W +: COEF_W];
    assign prod     = $signed({1'b0, win_reg[tap_sel]}) * coef_tap;
    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    // threshold compare in units of 1/256
    assign thr_ext = {{(ACC_W - THRESH_W - 8){1'b0}}, threshold_reg, 8'h00};
    assign new_bit = (acc_reg >= thr_ext);

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // status toward controller
    always_comb
    begin
        status.cmd_flush     = (item_reg.command == CMD_FLUSH);
        status.row_seen      = row_seen_reg;
        status.row_match     = (item_reg.row_index == cur_row_reg);
        status.will_fill     = (fill_reg >= FILL_W'(TAPS - 1));
        status.pending_valid = pend_valid_reg;
        status.held_valid    = held_valid_reg;
        status.out_free      = out_free;
    end

    // sample and column tag for a push
    always_comb
    begin
        case (cmd.src)
            SRC_FLUSH_PAD:
            begin
                push_pix = pad_mode_reg ? last_pix_reg : '0;
                push_tag = last_col_reg + 1'b1;
            end
            SRC_LEFT_PAD:
            begin
                push_pix = pad_mode_reg ? item_reg.first_pixel : '0;
                push_tag = '0;
            end
            SRC_FIRST:
            begin
                push_pix = item_reg.first_pixel;
                push_tag = item_reg.col_index;
            end
            default:
            begin
                push_pix = item_reg.second_pixel;
                push_tag = item_reg.col_index + 1'b1;
            end
        endcase
    end

    // result made by a commit or a lone flush
    always_comb
    begin
        emit_en   = 1'b0;
        emit_beat = '0;
        emit_beat.out_row   = cur_row_reg;
        emit_beat.out_col   = pend_col_reg;
        emit_beat.bit_first = pend_bit_reg;
        if (cmd.bit_commit && pend_valid_reg)
        begin
            emit_en              = 1'b1;
            emit_beat.bit_second = new_bit;
        end
        else if (cmd.emit_lone && pend_valid_reg)
        begin
            emit_en = 1'b1;
        end
    end

    // next state of config, window, row and pairing
    always_comb
    begin
        threshold_next  = threshold_reg;
        pad_mode_next   = pad_mode_reg;
        coef_low_next   = coef_low_reg;
        coef_high_next  = coef_high_reg;
        item_next       = item_reg;
        win_next        = win_reg;
        tag_next        = tag_reg;
        fill_next       = fill_reg;
        cur_row_next    = cur_row_reg;
        row_seen_next   = row_seen_reg;
        last_pix_next   = last_pix_reg;
        last_col_next   = last_col_reg;
        pend_bit_next   = pend_bit_reg;
        pend_col_next   = pend_col_reg;
        pend_valid_next = pend_valid_reg;
        acc_next        = acc_reg;

        // config write
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_next = cfg_data[THRESH_W-1:0];
                REG_PAD_MODE:  pad_mode_next  = cfg_data[0];
                REG_COEF_LOW:  coef_low_next  = cfg_data[COEF_LOW_W-1:0];
                REG_COEF_HIGH: coef_high_next = cfg_data[COEF_HIGH_W-1:0];
                default:       threshold_next = threshold_reg;
            endcase
        end

        if (cmd.load_item)
            item_next = pix_data;

        // shift one sample into the window
        if (cmd.push)
        begin
            for (int i = 0; i < TAPS - 1; i++)
                win_next[i] = win_reg[i + 1];
            win_next[TAPS - 1] = push_pix;
            for (int i = 0; i < NT - 1; i++)
                tag_next[i] = tag_reg[i + 1];
            tag_next[NT - 1] = push_tag;
            if (fill_reg != FILL_W'(TAPS))
                fill_next = fill_reg + 1'b1;
            if (cmd.src == SRC_FLUSH_PAD)
                last_col_next = push_tag;
            if (cmd.src == SRC_SECOND)
            begin
                last_pix_next = item_reg.second_pixel;
                last_col_next = push_tag;
            end
        end

        // multiply accumulate
        if (cmd.mac_step)
            acc_next = cmd.mac_first ? prod_ext : acc_reg + prod_ext;

        // pair bits
        if (cmd.bit_commit)
        begin
            if (pend_valid_reg)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                pend_bit_next   = new_bit;
                pend_col_next   = tag_reg[0];
                pend_valid_next = 1'b1;
            end
        end
        if (cmd.emit_lone)
            pend_valid_next = 1'b0;

        // row boundaries
        if (cmd.row_clear)
        begin
            row_seen_next   = 1'b0;
            fill_next       = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.row_start)
        begin
            cur_row_next    = item_reg.row_index;
            row_seen_next   = 1'b1;
            fill_next       = '0;
            pend_valid_next = 1'b0;
        end
    end

    // held result and output register
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        if (emit_en)
        begin
            held_next       = emit_beat;
            held_valid_next = 1'b1;
            if (held_valid_reg)
            begin
                out_next             = held_reg;
                out_next.last_of_run = 1'b0;
                out_valid_next       = 1'b1;
            end
        end
        else if (cmd.release_held && held_valid_reg)
        begin
            out_next             = held_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            held_valid_next      = 1'b0;
        end
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESH_RST;
            pad_mode_reg   <= PAD_MODE_RST;
            coef_low_reg   <= COEF_LOW_RST;
            coef_high_reg  <= COEF_HIGH_RST;
            fill_reg       <= '0;
            cur_row_reg    <= '0;
            row_seen_reg   <= 1'b0;
            last_pix_reg   <= '0;
            last_col_reg   <= '0;
            pend_bit_reg   <= 1'b0;
            pend_col_reg   <= '0;
            pend_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            threshold_reg  <= threshold_next;
            pad_mode_reg   <= pad_mode_next;
            coef_low_reg   <= coef_low_next;
            coef_high_reg  <= coef_high_next;
            fill_reg       <= fill_next;
            cur_row_reg    <= cur_row_next;
            row_seen_reg   <= row_seen_next;
            last_pix_reg   <= last_pix_next;
            last_col_reg   <= last_col_next;
            pend_bit_reg   <= pend_bit_next;
            pend_col_reg   <= pend_col_next;
            pend_valid_reg <= pend_valid_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        win_reg  <= win_next;
        tag_reg  <= tag_next;
        acc_reg  <= acc_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

`ifndef NO_ASSERTIONS
    // fill count saturates at the window length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TAPS))
        else $error("fill count beyond window length");

    // a result pushing out the held one only when the output beat is free
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_en && held_valid_reg) |-> out_free)
        else $error("held result overwritten while output busy");
`endif

endmodule

// File: design/row_fir_threshold_binarizer.sv
// row_fir_threshold_binarizer: top level joining the controller and the datapath
//
//   channel | valid / ready        | beat payload | direction
//   pix     | pix_valid/pix_ready  | pix_beat_t   | in
//   res     | res_valid/res_ready  | res_beat_t   | out
//   cfg     | cfg_we (no ready)    | cfg_index, cfg_data | in
//
// once the window is full a same-row beat runs: accept, decide, then per pixel a shift,
// a mac pass over every tap and a bit commit, then release of the held result.
// a row change runs right pads, each with shift, mac pass and bit commit, then lone,
// new-row, TAPS/2 left pads and two bare shifts; a flush runs the right pads, lone and release.
// pushes into a part-filled window skip the mac; reset is asynchronous active low.
// a stalled output holds the sequencer only when the held and output registers are full.
`timescale 1ns / 1ps

module row_fir_threshold_binarizer
    import rftb_pkg::*;
#(
    parameter int TAPS = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pix_beat_t             pix_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_beat_t             res_data
);

    ctrl_cmd_t               cmd;
    dp_status_t              status;
    logic [$clog2(TAPS)-1:0] tap_sel;

    // sequencer
    rftb_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .status    (status),
        .cmd       (cmd),
        .tap_sel   (tap_sel)
    );

    // window, mac and result staging
    rftb_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (pix_data),
        .cmd       (cmd),
        .tap_sel   (tap_sel),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// File: tb/row_fir_threshold_binarizer_check.sv
// row_fir_threshold_binarizer_check: channel monitor with result prediction and comparison
`timescale 1ns / 1ps

module row_fir_threshold_binarizer_check
    import rftb_pkg::*;
#(
    parameter int TAPS = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    input  logic                  pix_ready,
    input  pix_beat_t             pix_data,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  res_beat_t             res_data,
    output int                    mismatches,
    output int                    awaited_count
);

    localparam int HALF     = TAPS / 2;
    localparam int LOW_TAPS = 5;

    // register copy
    logic [THRESH_W-1:0]    thr;
    logic                   pad_rep;
    logic [COEF_LOW_W-1:0]  taps_lo;
    logic [COEF_HIGH_W-1:0] taps_hi;

    // window and row state
    logic [PIX_W-1:0] win_pix [TAPS];
    logic [IDX_W-1:0] win_col [TAPS];
    int               fill;
    logic [IDX_W-1:0] cur_row;
    logic             row_open;
    logic [PIX_W-1:0] edge_pix;
    logic [IDX_W-1:0] edge_col;
    logic             held_bit;
    logic [IDX_W-1:0] held_col;
    logic             held_ok;

    res_beat_t awaited_pairs[$];
    int        bad = 0;

    // signed q4.8 weight of one tap
    function automatic longint tap_weight(input int i);
        logic [COEF_W-1:0] raw;
        if (i < LOW_TAPS)
            raw = taps_lo[COEF_W*i +: COEF_W];
        else
            raw = taps_hi[COEF_W*(i-LOW_TAPS) +: COEF_W];
        return longint'($signed(raw));
    endfunction

    function automatic void queue_pair(input logic b1, input logic b2, input logic [IDX_W-1:0] col);
        res_beat_t r;
        r.bit_first   = b1;
        r.bit_second  = b2;
        r.out_row     = cur_row;
        r.out_col     = col;
        r.last_of_run = 1'b0;
        awaited_pairs.insert(awaited_pairs.size(), r);
    endfunction

    // shift one sample in; a full window gives one bit, bits pair up
    function automatic void slide_window(input logic [PIX_W-1:0] v, input logic [IDX_W-1:0] col);
        longint acc;
        logic   b;
        if (fill < TAPS)
        begin
            win_pix[fill] = v;
            win_col[fill] = col;
            fill++;
        end
        else
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                win_pix[i] = win_pix[i+1];
                win_col[i] = win_col[i+1];
            end
            win_pix[TAPS-1] = v;
            win_col[TAPS-1] = col;
        end
        if (fill < TAPS)
            return;
        acc = 0;
        for (int i = 0; i < TAPS; i++)
            acc += longint'(win_pix[i]) * tap_weight(i);
        b = (acc >= longint'(thr) * 256);
        if (!held_ok)
        begin
            held_bit = b;
            held_col = win_col[HALF];
            held_ok  = 1'b1;
        end
        else
        begin
            queue_pair(held_bit, b, held_col);
            held_ok = 1'b0;
        end
    endfunction

    // right pad of the closing row, then any lone bit
    function automatic void pad_row_end();
        logic [PIX_W-1:0] pad;
        pad = pad_rep ? edge_pix : '0;
        for (int i = 0; i < HALF; i++)
            slide_window(pad, edge_col + 1 + i);
        if (held_ok)
        begin
            queue_pair(held_bit, 1'b0, held_col);
            held_ok = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int               n_prior;
        logic [PIX_W-1:0] lpad;
        res_beat_t        want;
        res_beat_t        got;
        if (!rst_n)
        begin
            thr      = THRESH_RST;
            pad_rep  = PAD_MODE_RST;
            taps_lo  = COEF_LOW_RST;
            taps_hi  = COEF_HIGH_RST;
            fill     = 0;
            cur_row  = '0;
            row_open = 1'b0;
            edge_pix = '0;
            edge_col = '0;
            held_bit = 1'b0;
            held_col = '0;
            held_ok  = 1'b0;
            awaited_pairs.delete();
            mismatches    <= bad;
            awaited_count <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr     = cfg_data[THRESH_W-1:0];
                    REG_PAD_MODE:  pad_rep = cfg_data[0];
                    REG_COEF_LOW:  taps_lo = cfg_data[COEF_LOW_W-1:0];
                    REG_COEF_HIGH: taps_hi = cfg_data[COEF_HIGH_W-1:0];
                    default: ;
                endcase
            end

            // accepted input beat
            if (pix_valid && pix_ready)
            begin
                n_prior = awaited_pairs.size();
                if (pix_data.command == CMD_FLUSH)
                begin
                    if (row_open)
                    begin
                        pad_row_end();
                        row_open = 1'b0;
                        fill     = 0;
                        held_ok  = 1'b0;
                    end
                end
                else
                begin
                    // new row: close the old one, left pad the new one
                    if (!row_open || pix_data.row_index != cur_row)
                    begin
                        if (row_open)
                            pad_row_end();
                        cur_row  = pix_data.row_index;
                        row_open = 1'b1;
                        fill     = 0;
                        held_ok  = 1'b0;
                        lpad     = pad_rep ? pix_data.first_pixel : '0;
                        for (int i = 0; i < HALF; i++)
                            slide_window(lpad, '0);
                    end
                    slide_window(pix_data.first_pixel, pix_data.col_index);
                    slide_window(pix_data.second_pixel, pix_data.col_index + 1);
                    edge_pix = pix_data.second_pixel;
                    edge_col = pix_data.col_index + 1;
                end
                // mark the final result of this beat
                if (awaited_pairs.size() > n_prior)
                begin
                    want = awaited_pairs.pop_back();
                    want.last_of_run = 1'b1;
                    awaited_pairs.insert(awaited_pairs.size(), want);
                end
            end

            // accepted result beat
            if (res_valid && res_ready)
            begin
                got = res_data;
                if (awaited_pairs.size() == 0)
                begin
                    $error("result beat with nothing awaited: row %0h col %0h",
                           got.out_row, got.out_col);
                    bad++;
                end
                else
                begin
                    want = awaited_pairs.pop_front();
                    if (got.bit_first !== want.bit_first)
                    begin
                        $error("bit_first: expected %0b, got %0b", want.bit_first, got.bit_first);
                        bad++;
                    end
                    if (got.bit_second !== want.bit_second)
                    begin
                        $error("bit_second: expected %0b, got %0b",
                               want.bit_second, got.bit_second);
                        bad++;
                    end
                    if (got.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0h, got %0h", want.out_row, got.out_row);
                        bad++;
                    end
                    if (got.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0h, got %0h", want.out_col, got.out_col);
                        bad++;
                    end
                    if (got.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, got.last_of_run);
                        bad++;
                    end
                end
            end

            mismatches    <= bad;
            awaited_count <= awaited_pairs.size();
        end
    end

endmodule

// File: tb/row_fir_threshold_binarizer_test.sv
// row_fir_threshold_binarizer_test: stimulus, handshake idling and verdict for the binarizer
`timescale 1ns / 1ps

module row_fir_threshold_binarizer_test;
    import rftb_pkg::*;

    localparam int TAPS          = 9;
    localparam int SETTLE_CYCLES = 150;
    localparam int TAIL_CYCLES   = 200;
    localparam int HOLD_CYCLES   = 600;
    localparam int LIMIT_CYCLES  = 500000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  pix_valid;
    logic                  pix_ready;
    pix_beat_t             pix_data;
    logic                  res_valid;
    logic                  res_ready;
    res_beat_t             res_data;
    int                    mismatches;
    int                    awaited_count;

    int          snd_idle;
    int          rcv_stall;
    logic        hold_ask;
    int          cycles = 0;
    logic [31:0] row_ctr = 32'd2;

    row_fir_threshold_binarizer #(.TAPS(TAPS)) dut (.*);

    row_fir_threshold_binarizer_check #(.TAPS(TAPS)) watcher (.*);

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("row_fir_threshold_binarizer: mismatch");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ask = 1'b0;
            end
            res_ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // offer one beat after a random gap, return at the accepting edge
    task automatic send(input pix_beat_t b);
        while ($urandom_range(99) < snd_idle)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= b;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
    endtask

    task automatic send_pixels(input logic [31:0] row, input logic [31:0] col,
                               input logic [7:0] a, input logic [7:0] b);
        pix_beat_t p;
        p.command      = CMD_PIXELS;
        p.row_index    = row;
        p.col_index    = col;
        p.first_pixel  = a;
        p.second_pixel = b;
        send(p);
    endtask

    // flush beat; the other fields carry junk
    task automatic send_flush();
        pix_beat_t p;
        p.command      = CMD_FLUSH;
        p.row_index    = $urandom();
        p.col_index    = $urandom();
        p.first_pixel  = 8'($urandom_range(255));
        p.second_pixel = 8'($urandom_range(255));
        send(p);
    endtask

    // drop valid and wait until every awaited result beat is out
    task automatic settle(input int extra);
        pix_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // write all four registers while the block is idle
    task automatic load_setting(input logic [7:0] t, input logic p,
                                input logic [59:0] lo, input logic [47:0] hi);
        logic [63:0] junk;
        settle(SETTLE_CYCLES);
        junk = {$urandom(), $urandom()};
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= {junk[59:8], t};
        @(posedge clk);
        cfg_index <= REG_PAD_MODE;
        cfg_data  <= {junk[59:1], p};
        @(posedge clk);
        cfg_index <= REG_COEF_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_COEF_HIGH;
        cfg_data  <= {junk[59:48], hi};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly small positive taps, now and then a raw 12-bit value
    task automatic random_setting();
        logic [107:0] kern;
        logic [11:0]  w;
        for (int i = 0; i < TAPS; i++)
        begin
            if ($urandom_range(5) == 0)
                w = 12'($urandom_range(4095));
            else
                w = 12'($urandom_range(56)) - 12'd12;
            kern[12*i +: 12] = w;
        end
        load_setting(8'($urandom_range(150)), 1'($urandom_range(1)), kern[59:0], kern[107:60]);
    endtask

    // rows of consecutive pairs with flushes, mixed with noise beats
    task automatic stream(input int count);
        int          sent;
        int          len;
        logic [31:0] row;
        logic [31:0] col;
        logic [31:0] last_row;
        logic        flushed;
        pix_beat_t   b;
        sent     = 0;
        flushed  = 1'b0;
        last_row = '0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 12)
            begin
                b.command      = 1'($urandom_range(1));
                b.row_index    = $urandom();
                b.col_index    = $urandom();
                b.first_pixel  = rand_pixel();
                b.second_pixel = rand_pixel();
                send(b);
                if (b.command == CMD_PIXELS)
                    sent++;
            end
            else
            begin
                // reopen a flushed row now and then
                if (flushed && $urandom_range(3) == 0)
                    row = last_row;
                else if ($urandom_range(4) == 0)
                    row = $urandom();
                else
                begin
                    row = row_ctr;
                    row_ctr++;
                end
                col = ($urandom_range(2) == 0) ? 32'd0 : $urandom();
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    send_pixels(row, col, rand_pixel(), rand_pixel());
                    sent++;
                    col = col + (($urandom_range(9) == 0) ? $urandom_range(3, 40) : 2);
                end
                last_row = row;
                flushed  = ($urandom_range(2) == 0);
                if (flushed)
                    send_flush();
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= '0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        hold_ask  = 1'b0;
        snd_idle  = 35;
        rcv_stall = 75;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats on the reset setting (unit centre tap)
        send_flush();
        send_pixels(32'd0, 32'd0, 8'h00, 8'hFF);
        send_pixels(32'd0, 32'd2, 8'hFF, 8'h00);
        send_pixels(32'd0, 32'd4, 8'h80, 8'h7F);
        send_pixels(32'd0, 32'd6, 8'h55, 8'hAA);
        send_pixels(32'd0, 32'd100, 8'hAA, 8'h55);
        // row change, columns wrap past the top
        send_pixels(32'd1, 32'hFFFF_FFFC, 8'hC0, 8'h10);
        send_pixels(32'd1, 32'hFFFF_FFFE, 8'h90, 8'h7E);
        send_pixels(32'd1, 32'd0, 8'hFF, 8'h01);
        send_flush();
        // same row index after a flush opens a fresh row
        send_pixels(32'd1, 32'd0, 8'h81, 8'h00);
        send_pixels(32'd1, 32'd2, 8'h00, 8'hFE);
        // wrap inside one pair
        send_pixels(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_pixels(32'hFFFF_FFFF, 32'd1, 8'h7F, 8'h80);
        send_flush();
        send_flush();
        // one-pair rows
        send_pixels(32'h5555_5555, 32'hAAAA_AAAA, 8'hFF, 8'h00);
        send_pixels(32'hAAAA_AAAA, 32'h5555_5555, 8'h00, 8'hFF);
        send_flush();

        // extreme settings
        load_setting(8'd0, 1'b0, {5{12'h800}}, {4{12'h800}});
        stream(10);
        load_setting(8'd255, 1'b1, {5{12'h7FF}}, {4{12'h7FF}});
        stream(10);
        load_setting(8'd0, 1'b1, {5{12'hFFF}}, {4{12'hFFF}});
        stream(10);
        load_setting(8'd1, 1'b0, '0, '0);
        stream(10);

        // sender idles lightly, receiver heavily
        repeat (2)
        begin
            random_setting();
            stream(40);
        end

        // the other way round
        snd_idle  = 75;
        rcv_stall = 35;
        random_setting();
        stream(40);
        // long receiver hold while beats keep coming
        random_setting();
        snd_idle = 0;
        hold_ask = 1'b1;
        stream(40);
        snd_idle = 75;

        // no idling; one pause until the block drains
        snd_idle  = 0;
        rcv_stall = 0;
        random_setting();
        stream(20);
        settle(0);
        stream(20);
        random_setting();
        stream(40);
        send_flush();

        settle(TAIL_CYCLES);
        if (mismatches == 0)
            $display("row_fir_threshold_binarizer: match");
        else
            $display("row_fir_threshold_binarizer: mismatch");
        $finish;
    end

endmodule

// File: row_fir_threshold_binarizer.f
design/rftb_pkg.sv
design/rftb_ctrl.sv
design/rftb_datapath.sv
design/row_fir_threshold_binarizer.sv
tb/row_fir_threshold_binarizer_check.sv
tb/row_fir_threshold_binarizer_test.sv
